[src/lpcd_pkg.sv]
// Shared types and constants of the length-prefixed chunk deframer.
`default_nettype none

package lpcd_pkg;

  localparam logic [2:0] HdrIdxLenHi = 3'd4;
  localparam logic [2:0] HdrIdxLenLo = 3'd5;

  typedef struct packed {
    logic [31:0] chunk_seq;
    logic [15:0] chunk_len;
    logic [7:0]  payload_byte;
    logic [15:0] byte_offset;
    logic        last_in_chunk;
    logic        empty_chunk;
  } result_t;

  // Control between the parser and the stages around it.
  typedef struct packed {
    logic take;
    logic has_result;
  } parse_ctl_t;

endpackage

`default_nettype wire

[src/lpcd_if.sv]
// Valid/ready stream interfaces for raw bytes and for deframed results.
`default_nettype none

interface lpcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface lpcd_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] chunk_seq;
  logic [15:0] chunk_len;
  logic [7:0]  payload_byte;
  logic [15:0] byte_offset;
  logic        last_in_chunk;
  logic        empty_chunk;

  modport source (output valid, output chunk_seq, output chunk_len, output payload_byte,
                  output byte_offset, output last_in_chunk, output empty_chunk,
                  input ready);
  modport sink (input valid, input chunk_seq, input chunk_len, input payload_byte,
                input byte_offset, input last_in_chunk, input empty_chunk,
                output ready);
endinterface

`default_nettype wire

[src/lpcd_in_stage.sv]
// Input register of the deframer: holds one byte until the parser takes it.
`default_nettype none

module lpcd_in_stage
  import lpcd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lpcd_byte_if.sink   byte_i,
  input  wire logic   take_i,
  output logic        item_valid_o,
  output logic [7:0]  item_byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign byte_i.ready = !valid_q || take_i;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_i.data_byte;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;

endmodule

`default_nettype wire

[src/lpcd_parser.sv]
// Header and payload tracking, one byte per cycle unless the slot is full.
`default_nettype none

module lpcd_parser
  import lpcd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       item_valid_i,
  input  wire logic [7:0] item_byte_i,
  input  wire logic       slot_free_i,
  output parse_ctl_t      ctl_o,
  output result_t         result_o
);

  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [31:0] seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic        in_payload_q, in_payload_d;
  logic        has_result;
  logic        take;
  logic [16:0] next_off;
  logic [15:0] len_full;

  assign next_off = {1'b0, count_q} + 17'd1;
  assign len_full = {len_q[15:8], item_byte_i};

  always_comb begin
    hdr_idx_d    = hdr_idx_q;
    seq_d        = seq_q;
    len_d        = len_q;
    count_d      = count_q;
    in_payload_d = in_payload_q;
    has_result   = 1'b0;
    result_o     = '0;
    result_o.chunk_seq = seq_q;
    result_o.chunk_len = len_q;
    if (in_payload_q) begin
      has_result             = 1'b1;
      result_o.payload_byte  = item_byte_i;
      result_o.byte_offset   = count_q;
      result_o.last_in_chunk = (next_off == {1'b0, len_q});
      count_d                = next_off[15:0];
      if (result_o.last_in_chunk) begin
        in_payload_d = 1'b0;
        hdr_idx_d    = '0;
      end
    end else if (hdr_idx_q < HdrIdxLenHi) begin
      seq_d     = {seq_q[23:0], item_byte_i};
      hdr_idx_d = hdr_idx_q + 3'd1;
    end else if (hdr_idx_q == HdrIdxLenHi) begin
      len_d     = {item_byte_i, 8'h00};
      hdr_idx_d = HdrIdxLenLo;
    end else begin
      // Final header byte; out-of-range indexes complete the header as well.
      len_d     = len_full;
      hdr_idx_d = '0;
      count_d   = '0;
      if (len_full == 16'd0) begin
        has_result             = 1'b1;
        result_o.chunk_len     = 16'd0;
        result_o.last_in_chunk = 1'b1;
        result_o.empty_chunk   = 1'b1;
      end else begin
        in_payload_d = 1'b1;
      end
    end
  end

  // A header byte waits for the output slot only when it ends an empty chunk.
  assign take = item_valid_i && (!has_result || slot_free_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_idx_q    <= '0;
      seq_q        <= '0;
      len_q        <= '0;
      count_q      <= '0;
      in_payload_q <= 1'b0;
    end else if (take) begin
      hdr_idx_q    <= hdr_idx_d;
      seq_q        <= seq_d;
      len_q        <= len_d;
      count_q      <= count_d;
      in_payload_q <= in_payload_d;
    end
  end

  assign ctl_o.take       = take;
  assign ctl_o.has_result = has_result;

endmodule

`default_nettype wire

[src/lpcd_out_stage.sv]
// Result register of the deframer, driving the result channel.
`default_nettype none

module lpcd_out_stage
  import lpcd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire result_t  result_i,
  output logic          slot_free_o,
  lpcd_result_if.source result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign slot_free_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign result_o.valid         = valid_q;
  assign result_o.chunk_seq     = data_q.chunk_seq;
  assign result_o.chunk_len     = data_q.chunk_len;
  assign result_o.payload_byte  = data_q.payload_byte;
  assign result_o.byte_offset   = data_q.byte_offset;
  assign result_o.last_in_chunk = data_q.last_in_chunk;
  assign result_o.empty_chunk   = data_q.empty_chunk;

endmodule

`default_nettype wire

[src/length_prefixed_chunk_deframer_unit.sv]
// Top level of the length-prefixed chunk deframer.
//
// Raw stream bytes enter on byte_i, one byte per transaction. Each chunk is a
// 6-byte header (32-bit big-endian sequence number, 16-bit big-endian payload
// length) followed by that many payload bytes. Every payload byte leaves as
// one transaction on result_o with the chunk's sequence number and length,
// its offset and a last-in-chunk flag. A zero-length chunk gives a single
// result flagged empty and last on its final header byte; header bytes
// otherwise give nothing.
// A byte is registered in the input stage, then parsed and written to the
// result register, which drives result_o. Throughput is one byte per cycle
// while the receiver takes results; the parser updates its header/payload
// counters for each byte it takes.
// When the receiver stalls, the result register holds its transaction; the
// input register still takes one more byte, and header bytes, bar the final
// byte of an empty chunk, keep flowing since they need no result slot. Reset
// returns the parser to the start of a header and empties both registers.
`default_nettype none

module length_prefixed_chunk_deframer_unit
  import lpcd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lpcd_byte_if.sink     byte_i,
  lpcd_result_if.source result_o
);

  logic       item_valid;
  logic [7:0] item_byte;
  logic       slot_free;
  parse_ctl_t ctl;
  result_t    result;

  lpcd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_i),
    .take_i       (ctl.take),
    .item_valid_o (item_valid),
    .item_byte_o  (item_byte)
  );

  lpcd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_byte_i  (item_byte),
    .slot_free_i  (slot_free),
    .ctl_o        (ctl),
    .result_o     (result)
  );

  // A result is written only when the parser consumes a byte that makes one.
  lpcd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (ctl.take && ctl.has_result),
    .result_i    (result),
    .slot_free_o (slot_free),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

[tb/tb_length_prefixed_chunk_deframer_unit.sv]
// Self-checking testbench for the length-prefixed chunk deframer top level.
`timescale 1ns / 100ps

module tb_length_prefixed_chunk_deframer_unit
  import lpcd_pkg::*;
();

  // The run is capped well above the slowest legal run.
  localparam int unsigned CycleLimit = 100_000;
  localparam int unsigned ItemsPerPhase = 270;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxReported = 10;
  // Only a few results are ever in flight, so a small ring of expectations
  // is plenty.
  localparam int unsigned ExpIdxBits = 6;
  localparam int unsigned ExpDepth = 1 << ExpIdxBits;

  // One row of the directed stimulus. Where typed is set, the row carries the
  // result that it must cause. Every other row is checked against the
  // predictor.
  typedef struct packed {
    logic [7:0] data;
    logic       typed;
    result_t    want;
  } stim_row_t;

  // Software copy of the parser state.
  typedef struct {
    logic [2:0]  hdr_pos;
    logic [31:0] seq;
    logic [15:0] len;
    logic [15:0] count;
    logic        in_payload;
  } parser_state_t;

  localparam result_t NoResult = '0;
  // An all-zero header right after reset announces an empty chunk with sequence
  // number zero.
  localparam result_t EmptyAtReset = '{32'h0000_0000, 16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1};
  // A single-byte chunk that carries the largest sequence number and data byte.
  localparam result_t MaxSeqSingle = '{32'hFFFF_FFFF, 16'h0001, 8'hFF, 16'h0000, 1'b1, 1'b0};

  localparam int unsigned DirectedRows = 22;
  localparam stim_row_t directed_rows [DirectedRows] = '{
    // The empty chunk comes first. Its result appears on the sixth header
    // byte.
    '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h00, 1'b1, EmptyAtReset},
    // This chunk has sequence number FFFFFFFF and holds one payload byte.
    '{8'hFF, 1'b0, NoResult}, '{8'hFF, 1'b0, NoResult}, '{8'hFF, 1'b0, NoResult},
    '{8'hFF, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h01, 1'b0, NoResult},
    '{8'hFF, 1'b1, MaxSeqSingle},
    // This three-byte chunk has a mixed sequence number and the payload
    // bytes 00, A5 and 5A.
    '{8'h80, 1'b0, NoResult}, '{8'h01, 1'b0, NoResult}, '{8'h7E, 1'b0, NoResult},
    '{8'h55, 1'b0, NoResult}, '{8'h00, 1'b0, NoResult}, '{8'h03, 1'b0, NoResult},
    '{8'h00, 1'b0, NoResult}, '{8'hA5, 1'b0, NoResult}, '{8'h5A, 1'b0, NoResult}
  };

  logic clk = 1'b0;
  logic rst_n;

  lpcd_byte_if   byte_bus ();
  lpcd_result_if result_bus ();

  length_prefixed_chunk_deframer_unit DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .byte_i  (byte_bus),
    .result_o(result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  parser_state_t parser;
  result_t       expected_results [ExpDepth];
  int unsigned   exp_wr;
  int unsigned   exp_rd;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   fail_count;
  int unsigned   bytes_sent;
  int unsigned   results_checked;
  int unsigned   empty_chunks_seen;
  int unsigned   longest_chunk;
  int unsigned   cycle_count;

  // This function predicts what the block does with one accepted byte. It
  // returns 1 when the byte causes a result and places that result in res.
  function automatic bit deframe_byte(input logic [7:0] b, output result_t res);
    logic last;
    res = '0;
    if (parser.in_payload) begin
      // The compare uses 17 bits, so offset 65534 of a 65535-byte chunk
      // cannot wrap.
      last = ({1'b0, parser.count} + 17'd1) == {1'b0, parser.len};
      res.chunk_seq     = parser.seq;
      res.chunk_len     = parser.len;
      res.payload_byte  = b;
      res.byte_offset   = parser.count;
      res.last_in_chunk = last;
      res.empty_chunk   = 1'b0;
      parser.count = parser.count + 16'd1;
      if (last) begin
        parser.in_payload = 1'b0;
        parser.hdr_pos    = 3'd0;
      end
      return 1'b1;
    end
    if (parser.hdr_pos < HdrIdxLenHi) begin
      // Sequence bytes arrive most significant first. The old value shifts
      // out.
      parser.seq     = {parser.seq[23:0], b};
      parser.hdr_pos = parser.hdr_pos + 3'd1;
      return 1'b0;
    end
    if (parser.hdr_pos == HdrIdxLenHi) begin
      parser.len     = {b, 8'h00};
      parser.hdr_pos = HdrIdxLenLo;
      return 1'b0;
    end
    // The sixth header byte completes the header.
    parser.len[7:0] = b;
    parser.hdr_pos  = 3'd0;
    parser.count    = 16'd0;
    if (parser.len == 16'd0) begin
      res.chunk_seq     = parser.seq;
      res.last_in_chunk = 1'b1;
      res.empty_chunk   = 1'b1;
      return 1'b1;
    end
    parser.in_payload = 1'b1;
    return 1'b0;
  endfunction

  // This function picks the next random stream byte from the current parser
  // position. Most lengths are short. A few are in the hundreds.
  function automatic logic [7:0] pick_stream_byte();
    int unsigned roll;
    roll = $urandom_range(99);
    if (parser.in_payload) return 8'($urandom);
    case (parser.hdr_pos)
      HdrIdxLenHi: begin
        return (roll < 96) ? 8'h00 : 8'h01;
      end
      HdrIdxLenLo: begin
        if (roll < 15) return 8'h00;
        if (roll < 92) return 8'($urandom_range(1, 12));
        return 8'($urandom);
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // This task offers one byte, which may follow a random gap. It waits for the
  // transaction and records what the byte should cause. The task starts and
  // ends on a falling edge, so valid gets at most one update per time step.
  task automatic send_byte(input logic [7:0] b, input bit typed, input result_t want);
    result_t res;
    bit      has_res;
    while ($urandom_range(99) < send_idle_pct) begin
      byte_bus.valid     <= 1'b0;
      byte_bus.data_byte <= 8'($urandom);
      @(negedge clk);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.data_byte <= b;
    @(posedge clk);
    while (!byte_bus.ready) @(posedge clk);
    has_res = deframe_byte(b, res);
    // A typed row overrides the prediction. The predictor still runs to keep
    // its state current.
    if (typed) begin
      res     = want;
      has_res = 1'b1;
    end
    if (has_res) begin
      expected_results[exp_wr[ExpIdxBits-1:0]] = res;
      exp_wr++;
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  // This task sends random chunks until count bytes have gone. The stream
  // then runs on to a header boundary, so the next phase starts cleanly.
  task automatic send_random_chunks(input int unsigned count);
    int unsigned sent;
    logic [7:0]  b;
    sent = 0;
    while (sent < count || parser.in_payload || parser.hdr_pos != 3'd0) begin
      b = pick_stream_byte();
      send_byte(b, 1'b0, NoResult);
      sent++;
    end
  endtask

  // The receiver decides on each falling edge whether it takes a result on the
  // coming rising edge.
  always @(negedge clk) begin
    result_bus.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Each result transaction is compared with the oldest outstanding
  // expectation.
  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      got.chunk_seq     = result_bus.chunk_seq;
      got.chunk_len     = result_bus.chunk_len;
      got.payload_byte  = result_bus.payload_byte;
      got.byte_offset   = result_bus.byte_offset;
      got.last_in_chunk = result_bus.last_in_chunk;
      got.empty_chunk   = result_bus.empty_chunk;
      if (exp_wr == exp_rd) begin
        if (fail_count < MaxReported)
          $display("[%0t] unexpected result: seq=%h len=%h byte=%h off=%h last=%b empty=%b",
                   $time, got.chunk_seq, got.chunk_len, got.payload_byte, got.byte_offset,
                   got.last_in_chunk, got.empty_chunk);
        fail_count++;
      end else begin
        want = expected_results[exp_rd[ExpIdxBits-1:0]];
        exp_rd++;
        if (got.chunk_seq !== want.chunk_seq || got.chunk_len !== want.chunk_len ||
            got.payload_byte !== want.payload_byte || got.byte_offset !== want.byte_offset ||
            got.last_in_chunk !== want.last_in_chunk || got.empty_chunk !== want.empty_chunk)
        begin
          if (fail_count < MaxReported) begin
            $display("[%0t] result %0d mismatch", $time, results_checked);
            $display("  expected seq=%h len=%h byte=%h off=%h last=%b empty=%b",
                     want.chunk_seq, want.chunk_len, want.payload_byte, want.byte_offset,
                     want.last_in_chunk, want.empty_chunk);
            $display("  actual   seq=%h len=%h byte=%h off=%h last=%b empty=%b",
                     got.chunk_seq, got.chunk_len, got.payload_byte, got.byte_offset,
                     got.last_in_chunk, got.empty_chunk);
          end
          fail_count++;
        end
        results_checked++;
        if (want.empty_chunk) empty_chunks_seen++;
        else if (want.last_in_chunk && 32'(want.chunk_len) > longest_chunk)
          longest_chunk = 32'(want.chunk_len);
      end
    end
  end

  // A watchdog ends a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, exp_wr - exp_rd);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n               = 1'b0;
    byte_bus.valid      = 1'b0;
    byte_bus.data_byte  = 8'h00;
    result_bus.ready    = 1'b0;
    cycle_count         = 0;
    exp_wr              = 0;
    exp_rd              = 0;
    fail_count          = 0;
    bytes_sent          = 0;
    results_checked     = 0;
    empty_chunks_seen   = 0;
    longest_chunk       = 0;
    parser.hdr_pos      = 3'd0;
    parser.seq          = 32'h0;
    parser.len          = 16'h0;
    parser.count        = 16'h0;
    parser.in_payload   = 1'b0;
    send_idle_pct       = 17;
    recv_idle_pct       = 80;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The directed rows run first. They start right after reset and use the
    // idle mix of the first phase.
    for (int unsigned i = 0; i < DirectedRows; i++)
      send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

    // In the first phase the sender idles a little and the receiver stalls
    // often.
    send_random_chunks(ItemsPerPhase);

    // In the second phase the roles swap: the sender is sparse and the
    // receiver is eager.
    send_idle_pct = 80;
    recv_idle_pct = 17;
    send_random_chunks(ItemsPerPhase);

    // In the last phase neither side idles, so bytes and results move back
    // to back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_chunks(ItemsPerPhase);

    byte_bus.valid <= 1'b0;

    // The run waits for all results, then waits on to catch anything extra.
    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d stream bytes over three idle mixes and checked %0d results,",
             bytes_sent, results_checked);
    $display("including %0d empty chunks and a longest chunk of %0d bytes; %0d failures.",
             empty_chunks_seen, longest_chunk, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
src/lpcd_pkg.sv
src/lpcd_if.sv
src/lpcd_in_stage.sv
src/lpcd_parser.sv
src/lpcd_out_stage.sv
src/length_prefixed_chunk_deframer_unit.sv
tb/tb_length_prefixed_chunk_deframer_unit.sv
